// ===== src/rgbf_pkg.sv =====
// shared types and constants of the rgb 3x3 blur / sharpen filter
`timescale 1ns / 1ps
`default_nettype none
package rgbf_pkg;

   // input item kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // register indexes
   localparam logic CSR_FILTER_MODE = 1'b0;
   localparam logic CSR_IMAGE_SIDE  = 1'b1;
   localparam int   CSR_DATA_W      = 11;

   // filter modes
   localparam logic MODE_BLUR    = 1'b0;
   localparam logic MODE_SHARPEN = 1'b1;

   localparam int MIN_SIDE = 3;

   // x / 9 == (x * 7282) >> 16 for every window sum up to 9 * 255
   localparam int          DIV9_SHIFT = 16;
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int SUM_W   = 12;
   localparam int WIN_N   = 9;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic frame_end;
   } ctrl_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } out_type;

endpackage
`default_nettype wire

// ===== src/rgbf_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rgbf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/rgb_3x3_blur_sharpen_filter.sv =====
// top level of the rgb 3x3 blur / sharpen filter
//
// pixels of a square image enter on the req_ channel in raster order, one transfer per
// clock while not stalled; flush ops push out the last pixels once the image is in.
// each filtered pixel leaves on the rsp_ channel; rsp_frame_end marks the last one.
// csr_ writes set the filter mode and the image side (3..MAX_SIDE, clamped); a side
// write restarts the frame. write only while no item is in flight.
// throughput: one item per clock while req_stall is low. a line memory holding the
// two previous rows, read and written back at the input column, feeds the 3x3 window.
// the result for a pixel is produced by the item that arrives image_side + 1 items
// after it; it passes the memory read, window shift, window sum and filter steps and
// the result queue before it appears on rsp_.
// border pixels pass through, interior pixels are blurred or sharpened.
// a result queue of 8 entries decouples the sides: while rsp_stall is high the block
// keeps accepting until the queue and the 3 pipeline stages together hold 8 results,
// then raises req_stall. reset empties the pipeline and the queue and starts a new
// frame with blur mode and side 3; the line memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module rgb_3x3_blur_sharpen_filter #(
   parameter int MAX_SIDE = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_op,
   input  wire logic [7:0]                      req_red_in,
   input  wire logic [7:0]                      req_green_in,
   input  wire logic [7:0]                      req_blue_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_red_out,
   output logic [7:0]                           rsp_green_out,
   output logic [7:0]                           rsp_blue_out,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_write,
   input  wire logic                            csr_index,
   input  wire logic [rgbf_pkg::CSR_DATA_W-1:0] csr_data
);

   import rgbf_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int LW = $clog2(MAX_SIDE + 2);

   // configuration
   logic          mode_ff, mode_in;
   logic [SW-1:0] side_ff, side_in;
   logic [SW-1:0] side_m1, side_m2;
   logic [LW-1:0] side_p1;

   // frame positions
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [SW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [SW-1:0] out_row_ff, out_row_in;
   logic [LW-1:0] lag_ff, lag_in;

   logic [CW-1:0] cur_in_col, cur_out_col;
   logic [SW-1:0] cur_in_row, cur_out_row;
   logic [LW-1:0] cur_lag;

   logic     accept, is_pixel, in_done, out_done, restart, ignore, step, emit;
   logic     in_last_col, out_last_col;
   ctrl_type step_info;
   pixel_type step_pix;

   // stage 1: line memory read in flight
   logic      s1_valid_ff, s1_valid_in;
   logic      s1_store_ff;
   logic [CW-1:0] s1_col_ff;
   pixel_type s1_pix_ff;
   ctrl_type  s1_info_ff;

   // stage 2: window holds the neighborhood
   logic      s2_valid_ff, s2_valid_in;
   ctrl_type  s2_info_ff;
   pixel_type window_ff [WIN_N];
   logic [SUM_W-1:0] win_sum [3];

   // stage 3: per channel sums
   logic      s3_valid_ff, s3_valid_in;
   ctrl_type  s3_info_ff;
   logic [SUM_W-1:0]  sum_ff [3];
   logic [CHAN_W-1:0] center_ff [3];

   logic [SUM_W+12:0]     blur_prod [3];
   logic [SUM_W-1:0]      ten_c [3];
   logic signed [SUM_W+1:0] sharp_diff [3];
   logic [CHAN_W-1:0]     filt [3];

   // line memory
   logic          ram_wr_en, ram_rd_en;
   logic [CW-1:0] ram_wr_addr, ram_rd_addr;
   logic [2*PIX_W-1:0] ram_wr_data, ram_rd_data;

   // result queue
   out_type              fifo_ff [FIFO_DEPTH];
   out_type              push_data;
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic [FIFO_AW+1:0]   occupancy;
   logic                 fifo_push, fifo_pop;

   assign side_m1 = side_ff - SW'(1);
   assign side_m2 = side_ff - SW'(2);
   assign side_p1 = LW'(side_ff) + LW'(1);

   // room for everything in flight, so the pipeline itself never stalls
   assign occupancy = (FIFO_AW+2)'(count_ff) + (FIFO_AW+2)'(s1_valid_ff)
                    + (FIFO_AW+2)'(s2_valid_ff) + (FIFO_AW+2)'(s3_valid_ff);
   assign req_stall = occupancy >= (FIFO_AW+2)'(FIFO_DEPTH);

   always_comb begin
      accept   = req_valid && !req_stall;
      is_pixel = req_op == OP_PIXEL;
      in_done  = in_row_ff == side_ff;
      out_done = out_row_ff == side_ff;
      // a pixel after a complete image opens a new frame
      restart  = is_pixel && in_done;
      ignore   = !is_pixel && (!in_done || out_done);
      step     = accept && !ignore;

      cur_in_col  = restart ? '0 : in_col_ff;
      cur_in_row  = restart ? '0 : in_row_ff;
      cur_out_col = restart ? '0 : out_col_ff;
      cur_out_row = restart ? '0 : out_row_ff;
      cur_lag     = restart ? '0 : lag_ff;

      emit = (cur_out_row != side_ff) && (cur_lag == side_p1);
      in_last_col  = SW'(cur_in_col) == side_m1;
      out_last_col = SW'(cur_out_col) == side_m1;

      step_info.emit      = emit;
      step_info.interior  = (cur_out_row >= SW'(1)) && (cur_out_row <= side_m2)
                         && (SW'(cur_out_col) >= SW'(1)) && (SW'(cur_out_col) <= side_m2);
      step_info.frame_end = (cur_out_row == side_m1) && out_last_col;
      step_pix = is_pixel ? {req_red_in, req_green_in, req_blue_in} : '0;

      mode_in    = mode_ff;
      side_in    = side_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;

      if (step) begin
         in_col_in = in_last_col ? '0 : cur_in_col + CW'(1);
         in_row_in = (in_last_col && cur_in_row != side_ff) ? cur_in_row + SW'(1)
                                                           : cur_in_row;
         out_col_in = cur_out_col;
         out_row_in = cur_out_row;
         lag_in     = cur_lag;
         if (emit) begin
            out_col_in = out_last_col ? '0 : cur_out_col + CW'(1);
            out_row_in = out_last_col ? cur_out_row + SW'(1) : cur_out_row;
         end else if (cur_lag != side_p1) begin
            lag_in = cur_lag + LW'(1);
         end
      end

      if (csr_write) begin
         case (csr_index)
            CSR_FILTER_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_IMAGE_SIDE: begin
               if (csr_data < CSR_DATA_W'(MIN_SIDE)) begin
                  side_in = SW'(MIN_SIDE);
               end else if (32'(csr_data) > MAX_SIDE) begin
                  side_in = SW'(MAX_SIDE);
               end else begin
                  side_in = SW'(csr_data);
               end
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               lag_in     = '0;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // each entry holds {row two above, row above} of one column; consecutive items
   // always touch different columns, so the write back never meets a pending read
   assign ram_rd_en   = step;
   assign ram_rd_addr = cur_in_col;
   assign ram_wr_en   = s1_valid_ff && s1_store_ff;
   assign ram_wr_addr = s1_col_ff;
   assign ram_wr_data = {ram_rd_data[PIX_W-1:0], s1_pix_ff};

   rgbf_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign s1_valid_in = step;
   assign s2_valid_in = s1_valid_ff && s1_info_ff.emit;
   assign s3_valid_in = s2_valid_ff;

   // window sums per channel, channel 2 is red
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         win_sum[ch] = '0;
         for (int k = 0; k < WIN_N; k++) begin
            win_sum[ch] = win_sum[ch] + SUM_W'(window_ff[k][ch*CHAN_W +: CHAN_W]);
         end
      end
   end

   // filter per channel
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         blur_prod[ch]  = (SUM_W+13)'(sum_ff[ch]) * (SUM_W+13)'(DIV9_RECIP);
         ten_c[ch]      = SUM_W'({center_ff[ch], 3'b000}) + SUM_W'({center_ff[ch], 1'b0});
         sharp_diff[ch] = $signed({2'b00, ten_c[ch]}) - $signed({2'b00, sum_ff[ch]});
         if (!s3_info_ff.interior) begin
            filt[ch] = center_ff[ch];
         end else if (mode_ff == MODE_BLUR) begin
            filt[ch] = blur_prod[ch][DIV9_SHIFT +: CHAN_W];
         end else if (sharp_diff[ch] < 0) begin
            filt[ch] = '0;
         end else if (sharp_diff[ch] > (SUM_W+2)'(255)) begin
            filt[ch] = '1;
         end else begin
            filt[ch] = sharp_diff[ch][CHAN_W-1:0];
         end
      end
      push_data.red_out   = filt[2];
      push_data.green_out = filt[1];
      push_data.blue_out  = filt[0];
      push_data.frame_end = s3_info_ff.frame_end;
   end

   assign fifo_push = s3_valid_ff;
   assign fifo_pop  = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = fifo_push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = fifo_pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (fifo_push && !fifo_pop) begin
         count_in = count_ff + (FIFO_AW+1)'(1);
      end else if (!fifo_push && fifo_pop) begin
         count_in = count_ff - (FIFO_AW+1)'(1);
      end
   end

   assign rsp_valid     = count_ff != '0;
   assign rsp_red_out   = fifo_ff[rd_ptr_ff].red_out;
   assign rsp_green_out = fifo_ff[rd_ptr_ff].green_out;
   assign rsp_blue_out  = fifo_ff[rd_ptr_ff].blue_out;
   assign rsp_frame_end = fifo_ff[rd_ptr_ff].frame_end;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_BLUR;
         side_ff     <= SW'(MIN_SIDE);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         lag_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         for (int k = 0; k < WIN_N; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         mode_ff     <= mode_in;
         side_ff     <= side_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         lag_ff      <= lag_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (s1_valid_ff) begin
            for (int r = 0; r < 3; r++) begin
               window_ff[r*3]   <= window_ff[r*3+1];
               window_ff[r*3+1] <= window_ff[r*3+2];
            end
            window_ff[2] <= ram_rd_data[2*PIX_W-1:PIX_W];
            window_ff[5] <= ram_rd_data[PIX_W-1:0];
            window_ff[8] <= s1_pix_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (step) begin
         s1_store_ff <= is_pixel;
         s1_col_ff   <= cur_in_col;
         s1_pix_ff   <= step_pix;
         s1_info_ff  <= step_info;
      end
      if (s1_valid_ff) begin
         s2_info_ff <= s1_info_ff;
      end
      if (s2_valid_ff) begin
         s3_info_ff <= s2_info_ff;
         for (int ch = 0; ch < 3; ch++) begin
            sum_ff[ch]    <= win_sum[ch];
            center_ff[ch] <= window_ff[4][ch*CHAN_W +: CHAN_W];
         end
      end
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_ram_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("line memory write back meets a read of the same column");

   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> ((count_ff != (FIFO_AW+1)'(FIFO_DEPTH)) || fifo_pop))
      else $error("result queue overflow");

   a_out_after_in: assert property (@(posedge clock) disable iff (reset)
      (out_row_ff == side_ff) |-> (in_row_ff == side_ff))
      else $error("output frame finished before input frame");

   a_lag_bounded: assert property (@(posedge clock) disable iff (reset)
      lag_ff <= side_p1)
      else $error("input to output lag beyond one row plus one pixel");
`endif

endmodule
`default_nettype wire
